// ----- src/cigar_from_variant_sites_macros.svh -----
// assertion macros for the checker file
`ifndef CIGAR_FROM_VARIANT_SITES_MACROS_SVH
`define CIGAR_FROM_VARIANT_SITES_MACROS_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define CFVS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while arst_n is low
`define CFVS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/cfvs_pkg.sv -----
// shared types and constants for the variant site to cigar converter
package cfvs_pkg;

	localparam int POS_BITS_DEF = 32;
	localparam int CFG_W        = 32;
	localparam int CFG_IDX_W    = 1;
	localparam int QL_W         = 32;
	localparam int LEN_W        = 33;
	localparam int N_SLOTS      = 4;
	localparam int SLOT_IDX_W   = $clog2(N_SLOTS);
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

	localparam logic [CFG_IDX_W-1:0] REG_REF_LEN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_QRY_LEN = 1'b1;

	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	typedef enum logic [1:0] {
		OP_EQ = 2'd0,
		OP_X  = 2'd1,
		OP_D  = 2'd2,
		OP_I  = 2'd3
	} op_code_t;

	// one candidate operation; later marks that a following slot of the item will emit
	typedef struct packed {
		logic             en;
		op_code_t         code;
		logic [LEN_W-1:0] len;
		logic             later;
	} op_slot_t;

	// everything the back end needs for one item
	typedef struct packed {
		logic                      finish;
		op_slot_t [N_SLOTS-1:0]    slot;
	} op_batch_t;

endpackage

// ----- src/cfvs_front.sv -----
// front end: accepts items, tracks the cursors and builds the per-item operation slots
module cfvs_front #(
	parameter int POS_BITS = cfvs_pkg::POS_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [cfvs_pkg::CFG_W-1:0]  ref_len_cfg,
	input  logic [cfvs_pkg::CFG_W-1:0]  qry_len_cfg,
	input  logic                        site_valid,
	output logic                        site_stall,
	input  logic                        func,
	input  logic [POS_BITS-1:0]         ref_begin,
	input  logic [POS_BITS-1:0]         ref_end,
	input  logic [POS_BITS-1:0]         query_begin,
	input  logic [cfvs_pkg::QL_W-1:0]   query_allele_length,
	input  logic                        length_known,
	input  logic                        inverted,
	output logic                        push,
	output cfvs_pkg::op_batch_t         push_batch,
	input  logic                        queue_full
);
	import cfvs_pkg::*;

	localparam int SUM_W = ((POS_BITS > QL_W) ? POS_BITS : QL_W) + 1;
	localparam int W     = SUM_W + 1;

	logic [POS_BITS+CFG_W-1:0] ref_len_ext, qry_len_ext;
	logic [POS_BITS-1:0] ref_len_pos, qry_len_pos;
	logic [POS_BITS-1:0] rc_q, qc_q;
	logic [POS_BITS-1:0] a_r, a_q;
	logic [POS_BITS:0]   dr_c, dq_c, rl_c;
	logic [SUM_W-1:0]    nq_c;
	logic [POS_BITS-1:0] nq_sat;
	logic                keep, accept, adv, need;

	logic                v_s1, finish_s1;
	logic [POS_BITS:0]   dr_s1, dq_s1, rl_s1;
	logic [QL_W-1:0]     ql_s1;

	logic [W-1:0] dr_w, dq_w, rl_w, ql_w, diff_w, ndiff_w, x_w;
	logic         gap_eq, diff_neg;
	op_slot_t [N_SLOTS-1:0] slot;

	function automatic logic is_pos(input logic [W-1:0] v);
		return !v[W-1] && (|v);
	endfunction

	function automatic logic [LEN_W-1:0] clamp_len(input logic [W-1:0] v);
		if (|v[W-1:LEN_W])
			return LEN_MAX;
		return v[LEN_W-1:0];
	endfunction

	// config values taken to position width
	assign ref_len_ext = {{POS_BITS{1'b0}}, ref_len_cfg};
	assign qry_len_ext = {{POS_BITS{1'b0}}, qry_len_cfg};
	assign ref_len_pos = ref_len_ext[POS_BITS-1:0];
	assign qry_len_pos = qry_len_ext[POS_BITS-1:0];

	// a finish measures the tail, a site measures the gap; the borrow bit is the sign
	assign a_r  = func ? ref_len_pos : ref_begin;
	assign a_q  = func ? qry_len_pos : query_begin;
	assign dr_c = {1'b0, a_r} - {1'b0, rc_q};
	assign dq_c = {1'b0, a_q} - {1'b0, qc_q};
	assign rl_c = {1'b0, ref_end} - {1'b0, ref_begin};
	assign nq_c = SUM_W'(query_begin) + SUM_W'(query_allele_length);
	assign nq_sat = (|nq_c[SUM_W-1:POS_BITS]) ? {POS_BITS{1'b1}} : nq_c[POS_BITS-1:0];

	assign keep   = func || (length_known && !inverted && !dr_c[POS_BITS] && !dq_c[POS_BITS]);
	assign accept = site_valid && !site_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q <= '0;
			qc_q <= '0;
		end else if (accept) begin
			if (func) begin
				rc_q <= '0;
				qc_q <= '0;
			end else if (keep) begin
				rc_q <= ref_end;
				qc_q <= nq_sat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= accept && keep;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			finish_s1 <= func;
			dr_s1     <= dr_c;
			dq_s1     <= dq_c;
			rl_s1     <= rl_c;
			ql_s1     <= query_allele_length;
		end
	end

	// slot lengths in a signed width that holds every difference
	assign dr_w    = {{(W-POS_BITS-1){dr_s1[POS_BITS]}}, dr_s1};
	assign dq_w    = {{(W-POS_BITS-1){dq_s1[POS_BITS]}}, dq_s1};
	assign rl_w    = {{(W-POS_BITS-1){rl_s1[POS_BITS]}}, rl_s1};
	assign ql_w    = {{(W-QL_W){1'b0}}, ql_s1};
	assign diff_w  = rl_w - ql_w;
	assign ndiff_w = ql_w - rl_w;
	assign diff_neg = diff_w[W-1];
	assign x_w     = diff_neg ? rl_w : ql_w;
	assign gap_eq  = (dr_s1 == dq_s1);

	always_comb begin
		logic                   have;
		op_code_t               pc;
		logic [N_SLOTS-1:0]     chg;
		logic [N_SLOTS-1:0]     lat;

		slot[0].en    = is_pos(dr_w);
		slot[0].code  = gap_eq ? OP_EQ : OP_D;
		slot[0].len   = clamp_len(dr_w);
		slot[1].en    = !gap_eq && is_pos(dq_w);
		slot[1].code  = OP_I;
		slot[1].len   = clamp_len(dq_w);
		slot[2].en    = !finish_s1 && is_pos(x_w);
		slot[2].code  = OP_X;
		slot[2].len   = clamp_len(x_w);
		slot[3].en    = !finish_s1 && (|diff_w);
		slot[3].code  = diff_neg ? OP_I : OP_D;
		slot[3].len   = diff_neg ? clamp_len(ndiff_w) : clamp_len(diff_w);

		// a slot emits the pending op when its code differs from the previous enabled slot
		have = 1'b0;
		pc   = OP_EQ;
		chg  = '0;
		for (int j = 0; j < N_SLOTS; j++) begin
			if (slot[j].en) begin
				chg[j] = have && (slot[j].code != pc);
				have   = 1'b1;
				pc     = slot[j].code;
			end
		end
		lat = '0;
		for (int i = N_SLOTS - 2; i >= 0; i--)
			lat[i] = lat[i+1] | chg[i+1];
		for (int i = 0; i < N_SLOTS; i++)
			slot[i].later = lat[i];
	end

	always_comb begin
		need = finish_s1;
		for (int i = 0; i < N_SLOTS; i++)
			need = need | slot[i].en;
	end

	assign push              = v_s1 && need && !queue_full;
	assign adv               = !v_s1 || !need || !queue_full;
	assign site_stall        = !adv;
	assign push_batch.finish = finish_s1;
	assign push_batch.slot   = slot;

endmodule

// ----- src/cfvs_queue.sv -----
// short queue of operation batches between front and back end
module cfvs_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cfvs_pkg::op_batch_t  push_batch,
	output logic                 full,
	output logic                 head_valid,
	output cfvs_pkg::op_batch_t  head_batch,
	input  logic                 pop
);
	import cfvs_pkg::*;

	op_batch_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign full       = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_batch = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_batch;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- src/cfvs_back.sv -----
// back end: merges slots into the pending op and drives the result register
module cfvs_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_valid,
	input  cfvs_pkg::op_batch_t          head_batch,
	output logic                         pop,
	output logic                         op_valid,
	input  logic                         op_stall,
	output logic [1:0]                   op_code,
	output logic [cfvs_pkg::LEN_W-1:0]   op_length,
	output logic                         last_of_run
);
	import cfvs_pkg::*;

	logic [N_SLOTS-1:0]    done_q, en, rem, pick;
	logic [SLOT_IDX_W-1:0] sel_idx;
	op_slot_t              sel;
	logic                  pend_v_q;
	op_code_t              pend_code_q;
	logic [LEN_W-1:0]      pend_len_q;
	logic [LEN_W:0]        sum;
	logic [LEN_W-1:0]      merged;
	logic                  has_slot, last_rem, emit, emit_last, go, out_free;
	logic                  op_valid_q, last_q;
	op_code_t              code_q;
	logic [LEN_W-1:0]      len_q;

	always_comb begin
		for (int i = 0; i < N_SLOTS; i++)
			en[i] = head_batch.slot[i].en;
	end

	assign rem = en & ~done_q;

	// lowest slot still to do
	always_comb begin
		sel_idx = '0;
		for (int i = N_SLOTS - 1; i >= 0; i--) begin
			if (rem[i])
				sel_idx = SLOT_IDX_W'(i);
		end
	end

	assign pick     = N_SLOTS'(1) << sel_idx;
	assign sel      = head_batch.slot[sel_idx];
	assign has_slot = |rem;
	assign last_rem = ((rem & ~pick) == '0);
	assign sum      = {1'b0, pend_len_q} + {1'b0, sel.len};
	assign merged   = sum[LEN_W] ? LEN_MAX : sum[LEN_W-1:0];

	// without a slot left the item is a finish flushing the pending op
	assign emit      = pend_v_q && (has_slot ? (pend_code_q != sel.code) : 1'b1);
	assign emit_last = has_slot ? (!sel.later && !head_batch.finish) : 1'b1;
	assign out_free  = !op_valid_q || !op_stall;
	assign go        = head_valid && (!emit || out_free);
	assign pop       = go && (!has_slot || (last_rem && !head_batch.finish));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			pend_v_q    <= 1'b0;
			pend_code_q <= OP_EQ;
			pend_len_q  <= '0;
		end else if (go) begin
			if (has_slot) begin
				done_q   <= pop ? '0 : (done_q | pick);
				pend_v_q <= 1'b1;
				if (pend_v_q && (pend_code_q == sel.code)) begin
					pend_len_q <= merged;
				end else begin
					pend_code_q <= sel.code;
					pend_len_q  <= sel.len;
				end
			end else begin
				done_q      <= '0;
				pend_v_q    <= 1'b0;
				pend_code_q <= OP_EQ;
				pend_len_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			op_valid_q <= 1'b0;
		else if (go && emit)
			op_valid_q <= 1'b1;
		else if (!op_stall)
			op_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			code_q <= pend_code_q;
			len_q  <= pend_len_q;
			last_q <= emit_last;
		end
	end

	assign op_valid    = op_valid_q;
	assign op_code     = code_q;
	assign op_length   = len_q;
	assign last_of_run = last_q;

endmodule

// ----- src/cigar_from_variant_sites.sv -----
// path: an accepted item is registered in the front stage, then held in the batch queue, and its slots
//   merge into the pending op before it is loaded into the result register
// throughput: the back end's merge adder takes one operation slot per cycle unless a stalled result
//   register holds it back; dropped sites cost none in the back
// the front accepts one item per cycle while the 4-entry batch queue has room
// reset (arst_n low, asynchronous): cursors, pending op, queue, result valid and
//   both length registers go to zero
module cigar_from_variant_sites #(
	parameter int POS_BITS = cfvs_pkg::POS_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cfvs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cfvs_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            site_valid,
	output logic                            site_stall,
	input  logic                            func,
	input  logic [POS_BITS-1:0]             ref_begin,
	input  logic [POS_BITS-1:0]             ref_end,
	input  logic [POS_BITS-1:0]             query_begin,
	input  logic [cfvs_pkg::QL_W-1:0]       query_allele_length,
	input  logic                            length_known,
	input  logic                            inverted,
	output logic                            op_valid,
	input  logic                            op_stall,
	output logic [1:0]                      op_code,
	output logic [cfvs_pkg::LEN_W-1:0]      op_length,
	output logic                            last_of_run
);
	import cfvs_pkg::*;

	logic [CFG_W-1:0] ref_len_q, qry_len_q;
	logic             push, queue_full, head_valid, pop;
	op_batch_t        push_batch, head_batch;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_len_q <= '0;
			qry_len_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_REF_LEN: ref_len_q <= cfg_data;
				REG_QRY_LEN: qry_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cfvs_front #(
		.POS_BITS(POS_BITS)
	) u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.ref_len_cfg         (ref_len_q),
		.qry_len_cfg         (qry_len_q),
		.site_valid          (site_valid),
		.site_stall          (site_stall),
		.func                (func),
		.ref_begin           (ref_begin),
		.ref_end             (ref_end),
		.query_begin         (query_begin),
		.query_allele_length (query_allele_length),
		.length_known        (length_known),
		.inverted            (inverted),
		.push                (push),
		.push_batch          (push_batch),
		.queue_full          (queue_full)
	);

	cfvs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_batch (push_batch),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_batch (head_batch),
		.pop        (pop)
	);

	cfvs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_batch  (head_batch),
		.pop         (pop),
		.op_valid    (op_valid),
		.op_stall    (op_stall),
		.op_code     (op_code),
		.op_length   (op_length),
		.last_of_run (last_of_run)
	);

endmodule

// ----- src/cfvs_checker.sv -----
// port-level checker for the converter, bound to the top level
`include "cigar_from_variant_sites_macros.svh"

module cfvs_checker #(
	parameter int POS_BITS = cfvs_pkg::POS_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          site_valid,
	input logic                          site_stall,
	input logic                          func,
	input logic [POS_BITS-1:0]           ref_begin,
	input logic [POS_BITS-1:0]           ref_end,
	input logic [POS_BITS-1:0]           query_begin,
	input logic [cfvs_pkg::QL_W-1:0]     query_allele_length,
	input logic                          length_known,
	input logic                          inverted,
	input logic                          op_valid,
	input logic                          op_stall,
	input logic [1:0]                    op_code,
	input logic [cfvs_pkg::LEN_W-1:0]    op_length,
	input logic                          last_of_run
);
	import cfvs_pkg::*;

	logic       seen_q, prev_open_q;
	logic [1:0] prev_code_q;

	// an op inside a run that is not its last must be followed by a different code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			prev_open_q <= 1'b0;
			prev_code_q <= '0;
		end else begin
			if (site_valid && !site_stall)
				seen_q <= 1'b1;
			if (op_valid && !op_stall) begin
				prev_open_q <= !last_of_run;
				prev_code_q <= op_code;
			end
		end
	end

	`CFVS_ASSERT_NEXT(a_site_hold, site_valid && site_stall, site_valid && $stable(func) && $stable(ref_begin) && $stable(ref_end) && $stable(query_begin) && $stable(query_allele_length) && $stable(length_known) && $stable(inverted), "stalled item changed")
	`CFVS_ASSERT_NEXT(a_op_hold, op_valid && op_stall, op_valid && $stable(op_code) && $stable(op_length) && $stable(last_of_run), "stalled result changed")
	`CFVS_ASSERT_NOW(a_op_after_item, op_valid, seen_q, "result without any accepted item")
	`CFVS_ASSERT_NOW(a_run_code_change, op_valid && prev_open_q, op_code != prev_code_q, "unmerged ops of equal code in one run")

endmodule

bind cigar_from_variant_sites cfvs_checker #(.POS_BITS(POS_BITS)) u_cfvs_checker (.*);

// ----- tb/sv/tb_cigar_from_variant_sites.sv -----
// self-checking testbench for the variant site to cigar converter
`timescale 1ns / 100ps

module tb_cigar_from_variant_sites;
	import cfvs_pkg::*;

	localparam int     IDLE_WAIT  = 40;
	localparam int     WDOG_LIMIT = 2000;
	localparam longint LEN_TOP    = longint'(LEN_MAX);

	typedef struct packed {
		logic        fin;
		logic [31:0] rb;
		logic [31:0] re;
		logic [31:0] qb;
		logic [31:0] ql;
		logic        known;
		logic        inv;
	} site_t;

	typedef struct packed {
		op_code_t         code;
		logic [LEN_W-1:0] len;
		logic             last;
	} op_t;

	// set_len rows write both length registers instead of sending an item
	typedef struct {
		bit          set_len;
		logic [31:0] len_ref;
		logic [31:0] len_qry;
		site_t       site;
		int          n_fixed;
		op_t         fixed;
	} row_t;

	localparam op_t NO_OP = '{OP_EQ, '0, 1'b0};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_REF_LEN;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 site_valid = 1'b0;
	logic                 site_stall;
	logic                 func = 1'b0;
	logic [31:0]          ref_begin = '0;
	logic [31:0]          ref_end = '0;
	logic [31:0]          query_begin = '0;
	logic [QL_W-1:0]      query_allele_length = '0;
	logic                 length_known = 1'b0;
	logic                 inverted = 1'b0;
	logic                 op_valid;
	logic                 op_stall = 1'b0;
	logic [1:0]           op_code;
	logic [LEN_W-1:0]     op_length;
	logic                 last_of_run;

	cigar_from_variant_sites u_top (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.site_valid          (site_valid),
		.site_stall          (site_stall),
		.func                (func),
		.ref_begin           (ref_begin),
		.ref_end             (ref_end),
		.query_begin         (query_begin),
		.query_allele_length (query_allele_length),
		.length_known        (length_known),
		.inverted            (inverted),
		.op_valid            (op_valid),
		.op_stall            (op_stall),
		.op_code             (op_code),
		.op_length           (op_length),
		.last_of_run         (last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// converter state as the testbench sees it
	logic [31:0]      cur_ref, cur_qry;
	logic [31:0]      reg_ref_len, reg_qry_len;
	op_code_t         pend_code;
	logic [LEN_W-1:0] pend_len;
	bit               pend_on;
	op_t              batch [N_SLOTS];
	int               nb;

	op_t              ops_due [$];
	row_t             rows [$];
	int               errors = 0;
	bit               calm = 1'b0;
	int unsigned      hold = 0;
	int               idle_cycles = 0;

	function automatic int unsigned pause_len();
		return calm ? 0 : $urandom_range(0, 12);
	endfunction

	// append one op to the list of results still owed by the block
	function void due_op(op_t o);
		ops_due.insert(ops_due.size(), o);
	endfunction

	function void put_op(op_code_t c, logic [LEN_W-1:0] l);
		if (nb < N_SLOTS) begin
			batch[nb] = '{c, l, 1'b0};
			nb++;
		end
	endfunction

	// merge with the pending op or retire it; non-positive lengths vanish
	function automatic void merge_op(op_code_t c, longint n);
		logic [LEN_W:0]   sum;
		logic [LEN_W-1:0] l;
		if (n <= 0)
			return;
		l = (n > LEN_TOP) ? LEN_MAX : n[LEN_W-1:0];
		if (pend_on && pend_code == c) begin
			sum = {1'b0, pend_len} + {1'b0, l};
			pend_len = sum[LEN_W] ? LEN_MAX : sum[LEN_W-1:0];
			return;
		end
		if (pend_on)
			put_op(pend_code, pend_len);
		pend_code = c;
		pend_len = l;
		pend_on = 1'b1;
	endfunction

	function automatic void fill_gap(longint dr, longint dq);
		if (dr == dq) begin
			merge_op(OP_EQ, dr);
		end else begin
			merge_op(OP_D, dr);
			merge_op(OP_I, dq);
		end
	endfunction

	// returns 1 when the item did something (finish or taken site)
	function automatic bit predict_ops(site_t s);
		longint         rl, qn;
		logic [32:0]    nq;
		bit             acted;
		nb = 0;
		acted = s.fin || (s.known && s.rb >= cur_ref && s.qb >= cur_qry && !s.inv);
		if (s.fin) begin
			fill_gap(longint'(reg_ref_len) - longint'(cur_ref),
				longint'(reg_qry_len) - longint'(cur_qry));
			if (pend_on)
				put_op(pend_code, pend_len);
			pend_on = 1'b0;
			pend_code = OP_EQ;
			pend_len = '0;
			cur_ref = '0;
			cur_qry = '0;
		end else if (acted) begin
			rl = longint'(s.re) - longint'(s.rb);
			qn = longint'(s.ql);
			fill_gap(longint'(s.rb - cur_ref), longint'(s.qb - cur_qry));
			merge_op(OP_X, (rl < qn) ? rl : qn);
			merge_op(OP_D, rl - qn);
			merge_op(OP_I, qn - rl);
			cur_ref = s.re;
			nq = {1'b0, s.qb} + {1'b0, s.ql};
			cur_qry = nq[32] ? '1 : nq[31:0];
		end
		if (nb > 0)
			batch[nb-1].last = 1'b1;
		return acted;
	endfunction

	function void queue_batch();
		for (int i = 0; i < nb; i++)
			due_op(batch[i]);
	endfunction

	function automatic site_t mk(logic fin, logic [31:0] rb, logic [31:0] re,
		logic [31:0] qb, logic [31:0] ql, logic known, logic inv);
		site_t s;
		s = '{fin, rb, re, qb, ql, known, inv};
		return s;
	endfunction

	task automatic add_row(site_t s, int n_fixed, op_t f);
		row_t r;
		r.set_len = 1'b0;
		r.len_ref = '0;
		r.len_qry = '0;
		r.site = s;
		r.n_fixed = n_fixed;
		r.fixed = f;
		rows.insert(rows.size(), r);
	endtask

	task automatic add_len_row(logic [31:0] lr, logic [31:0] lq);
		row_t r;
		r.set_len = 1'b1;
		r.len_ref = lr;
		r.len_qry = lq;
		r.site = '0;
		r.n_fixed = 0;
		r.fixed = NO_OP;
		rows.insert(rows.size(), r);
	endtask

	// mostly well-formed sites that follow the cursors, some broken ones and noise
	function automatic site_t roll_site();
		site_t       s;
		int unsigned k, gr, gq, lr;
		s = mk(1'b0, $urandom, $urandom, $urandom, $urandom,
			$urandom_range(0, 1), $urandom_range(0, 1));
		k = $urandom_range(0, 99);
		if (k < 8 || cur_ref > 32'hFFFF_0000 || cur_qry > 32'hFFFF_0000) begin
			s.fin = 1'b1;
		end else if (k < 88) begin
			gr = $urandom_range(0, 20);
			gq = ($urandom_range(0, 9) < 6) ? gr : $urandom_range(0, 20);
			lr = $urandom_range(0, 12);
			s.rb = cur_ref + gr;
			s.qb = cur_qry + gq;
			s.re = s.rb + lr;
			s.ql = ($urandom_range(0, 9) < 4) ? lr : $urandom_range(0, 12);
			s.known = 1'b1;
			s.inv = 1'b0;
			if (k >= 84)
				s.known = 1'b0;
			else if (k >= 81)
				s.inv = 1'b1;
			else if (k >= 78)
				s.re = s.rb - $urandom_range(1, 10);
			else if (k >= 75)
				s.qb = cur_qry - 1;
		end
		return s;
	endfunction

	task automatic send_site(site_t s);
		int unsigned gap;
		gap = pause_len();
		if (gap != 0) begin
			site_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		site_valid <= 1'b1;
		func <= s.fin;
		ref_begin <= s.rb;
		ref_end <= s.re;
		query_begin <= s.qb;
		query_allele_length <= s.ql;
		length_known <= s.known;
		inverted <= s.inv;
		do @(posedge clk); while (site_stall);
	endtask

	task automatic drain();
		site_valid <= 1'b0;
		while (ops_due.size() != 0)
			@(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic set_lengths(logic [31:0] lr, logic [31:0] lq);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= REG_REF_LEN;
		cfg_data <= lr;
		do @(posedge clk); while (!cfg_ready);
		reg_ref_len = lr;
		cfg_index <= REG_QRY_LEN;
		cfg_data <= lq;
		do @(posedge clk); while (!cfg_ready);
		reg_qry_len = lq;
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin : op_sink
		op_t         want;
		int unsigned d;
		if (arst_n) begin
			if (op_valid && !op_stall) begin
				if (ops_due.size() == 0) begin
					if (errors < 10)
						$display("unexpected op: code %0d len %0d last %0b",
							op_code, op_length, last_of_run);
					errors++;
				end else begin
					want = ops_due.pop_front();
					if (op_code !== want.code || op_length !== want.len ||
						last_of_run !== want.last) begin
						if (errors < 10)
							$display("op mismatch: exp %0d/%0d/%0b got %0d/%0d/%0b",
								want.code, want.len, want.last,
								op_code, op_length, last_of_run);
						errors++;
					end
				end
				d = pause_len();
				hold <= d;
				op_stall <= (d != 0);
			end else if (hold != 0) begin
				hold <= hold - 1;
				op_stall <= (hold > 1);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((site_valid && !site_stall) || (op_valid && !op_stall) ||
				(cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WDOG_LIMIT) begin
				$display("tb_cigar_from_variant_sites failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		row_t        r;
		site_t       s;
		int          done;
		int          phase;
		logic [31:0] lr, lq;
		bit          acted;
		cur_ref = '0;
		cur_qry = '0;
		reg_ref_len = '0;
		reg_qry_len = '0;
		pend_on = 1'b0;
		pend_code = OP_EQ;
		pend_len = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lengths are zero out of reset
		add_row(mk(1, 0, 0, 0, 0, 0, 0), 0, NO_OP);
		add_row(mk(0, 5, 9, 5, 4, 0, 0), 0, NO_OP);
		add_row(mk(0, 2, 4, 2, 2, 1, 1), 0, NO_OP);
		add_row(mk(0, 10, 12, 10, 2, 1, 0), 1, '{OP_EQ, 33'd10, 1'b1});
		add_row(mk(0, 5, 30, 20, 1, 1, 0), 0, NO_OP);
		add_row(mk(0, 20, 22, 3, 1, 1, 0), 0, NO_OP);
		add_row(mk(0, 12, 20, 12, 3, 1, 0), 1, '{OP_X, 33'd5, 1'b1});
		add_row(mk(0, 20, 20, 15, 4, 1, 0), -1, NO_OP);
		// end before begin
		add_row(mk(0, 30, 25, 19, 2, 1, 0), -1, NO_OP);
		// tail lies behind both cursors, only the flush remains
		add_row(mk(1, 0, 0, 0, 0, 0, 0), 1, '{OP_I, 33'd7, 1'b1});
		add_len_row(32'd100, 32'd100);
		add_row(mk(1, 0, 0, 0, 0, 0, 0), 1, '{OP_EQ, 33'd100, 1'b1});
		// query cursor saturates, then a site sits exactly on it
		add_row(mk(0, 0, 1, 32'hFFFF_FFF0, '1, 1, 0), -1, NO_OP);
		add_row(mk(0, 1, 1, '1, 0, 1, 0), -1, NO_OP);
		add_row(mk(1, 0, 0, 0, 0, 0, 0), -1, NO_OP);
		add_len_row('1, '1);
		// insertion run grows past the length range and saturates
		add_row(mk(0, '1, 0, 0, '1, 1, 0), -1, NO_OP);
		add_row(mk(0, 0, 0, '1, 1, 1, 0), -1, NO_OP);
		add_row(mk(0, 0, 0, '1, '1, 1, 0), -1, NO_OP);
		add_row(mk(1, 0, 0, 0, 0, 0, 0), -1, NO_OP);
		add_row(mk(0, '1, '1, '1, '1, 1, 0), -1, NO_OP);
		add_row(mk(1, 0, 0, 0, 0, 0, 0), -1, NO_OP);
		add_len_row('0, '1);
		add_row(mk(1, 0, 0, 0, 0, 0, 0), 1, '{OP_I, 33'h0_FFFF_FFFF, 1'b1});
		add_row(mk(0, 0, 8, 0, 3, 1, 0), -1, NO_OP);
		add_row(mk(1, 0, 0, 0, 0, 0, 0), -1, NO_OP);

		foreach (rows[i]) begin
			r = rows[i];
			calm = (i < 6);
			if (r.set_len) begin
				set_lengths(r.len_ref, r.len_qry);
			end else begin
				send_site(r.site);
				acted = predict_ops(r.site);
				if (r.n_fixed < 0)
					queue_batch();
				else if (r.n_fixed == 1)
					due_op(r.fixed);
			end
		end

		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					lr = $urandom_range(200, 600);
					lq = $urandom_range(200, 600);
				end
				1: begin
					lr = '0;
					lq = '0;
				end
				2: begin
					lr = '1;
					lq = '1;
				end
				3: begin
					lr = $urandom;
					lq = $urandom;
				end
				default: begin
					lr = $urandom_range(0, 300);
					lq = $urandom_range(0, 300);
				end
			endcase
			set_lengths(lr, lq);
			done = 0;
			while (done < 22) begin
				// a burst with no idling at the start of every phase
				calm = (done < 6);
				s = roll_site();
				send_site(s);
				acted = predict_ops(s);
				queue_batch();
				if (acted)
					done++;
			end
		end

		drain();
		if (errors == 0 && ops_due.size() == 0) begin
			$display("tb_cigar_from_variant_sites passed");
		end else begin
			$display("tb_cigar_from_variant_sites failed");
		end
		$finish;
	end

endmodule
